>>> src/mcr_pkg.sv
// shared types and constants of the midpoint circle rasterizer
package mcr_pkg;

    // coordinate width of the stepping state and the center registers
    localparam int COORD_BITS = 11;
    // radius register width
    localparam int RADIUS_BITS = COORD_BITS - 1;
    // width of the decision term and of the pixel coordinates
    localparam int OUT_BITS = COORD_BITS + 2;

    // eight symmetric pixels per step
    localparam int PIXELS_PER_STEP = 8;
    localparam int IDX_BITS = $clog2(PIXELS_PER_STEP);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(PIXELS_PER_STEP - 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = COORD_BITS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS   = 2'd2;

    // register reset values
    localparam logic [COORD_BITS-1:0]  CENTER_X_RST = COORD_BITS'(100);
    localparam logic [COORD_BITS-1:0]  CENTER_Y_RST = COORD_BITS'(100);
    localparam logic [RADIUS_BITS-1:0] RADIUS_RST   = RADIUS_BITS'(50);

    // configuration seen by the front
    typedef struct packed {
        logic [COORD_BITS-1:0]  center_x;
        logic [COORD_BITS-1:0]  center_y;
        logic [RADIUS_BITS-1:0] radius;
    } cfg_t;

    // one step command: either the done result or eight pixels of (x, y)
    typedef struct packed {
        logic                  done;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
    } cmd_t;

    // queue status toward its neighbors
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

>>> src/midpoint_circle_rasterizer_unit.sv
// top level of the midpoint circle rasterizer: configuration, front, queue and back
// an advance command goes through the queue and the back's command register before
// its first result is registered onto m_valid; while m_ready holds the back gives one
// result per cycle: eight pixels per pixel step, one done result per done tick, and
// no result for a restart tick; one pixel a cycle per step sets the sustained rate
// reset (aresetn low, synchronous) clears the state and loads the register defaults
module midpoint_circle_rasterizer_unit
    import mcr_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_restart,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_BITS-1:0] m_pixel_x,
    output logic signed [OUT_BITS-1:0] m_pixel_y,
    output logic                       m_pixel_valid,
    output logic                       m_last_of_step,
    output logic                       m_circle_done
);

    logic [COORD_BITS-1:0]  center_x_reg;
    logic [COORD_BITS-1:0]  center_y_reg;
    logic [RADIUS_BITS-1:0] radius_reg;
    cfg_t                   cfg;
    q_stat_t                q_stat;
    logic                   push;
    logic                   pop;
    cmd_t                   push_data;
    cmd_t                   pop_data;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            radius_reg   <= RADIUS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                CFG_RADIUS:   radius_reg   <= cfg_data[RADIUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.center_x = center_x_reg;
    assign cfg.center_y = center_y_reg;
    assign cfg.radius   = radius_reg;

    mcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    mcr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    mcr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .pop_data       (pop_data),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_valid  (m_pixel_valid),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

    // a done result is a lone, pixel-free end of its tick
    a_done_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_circle_done |-> m_last_of_step && !m_pixel_valid)
        else $error("done result with pixel or without last marker");

    // the queue is never written while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("command queue overflow");

    // a restart tick never issues a command
    a_restart_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_restart |-> !push)
        else $error("restart tick issued a command");

    // pixels of one step follow without a gap
    a_step_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_pixel_valid && !m_last_of_step
        |=> m_valid && m_pixel_valid)
        else $error("gap inside a pixel step");

endmodule

>>> src/mcr_queue.sv
// small command queue between the step front and the pixel back
module mcr_queue
    import mcr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_data,
    input  logic    pop,
    output cmd_t    pop_data,
    output q_stat_t stat
);

    cmd_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data       = mem_reg[rd_ptr_reg];
    assign stat.full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign stat.not_empty = (count_reg != '0);

endmodule

>>> src/mcr_front.sv
// step front: takes ticks, keeps the midpoint state, issues step commands
module mcr_front
    import mcr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    s_restart,
    input  q_stat_t q_stat,
    output logic    push,
    output cmd_t    push_data
);

    logic [COORD_BITS-1:0] step_x_reg, step_x_next;
    logic [COORD_BITS-1:0] step_y_reg, step_y_next;
    logic [OUT_BITS-1:0]   decision_reg, decision_next;
    logic                  active_reg, active_next;

    logic                  accept;
    logic                  finished;
    logic [OUT_BITS-1:0]   x_inc;
    logic [OUT_BITS-1:0]   y_dec;
    logic [OUT_BITS-1:0]   dec_step;

    assign s_ready  = !q_stat.full;
    assign accept   = s_valid && s_ready;
    assign finished = !active_reg || (step_x_reg >= step_y_reg);

    // command for an advance tick
    always_comb begin
        push_data.done     = finished;
        push_data.x        = step_x_reg;
        push_data.y        = step_y_reg;
        push_data.center_x = cfg.center_x;
        push_data.center_y = cfg.center_y;
        push               = accept && !s_restart;
    end

    // midpoint decision update
    always_comb begin
        x_inc = OUT_BITS'(step_x_reg) + 1'b1;
        y_dec = OUT_BITS'(step_y_reg);
        if (decision_reg[OUT_BITS-1]) begin
            dec_step = decision_reg + {x_inc[OUT_BITS-2:0], 1'b1};
        end else begin
            y_dec    = OUT_BITS'(step_y_reg) - 1'b1;
            dec_step = decision_reg + {x_inc[OUT_BITS-2:0] - y_dec[OUT_BITS-2:0], 1'b1};
        end
    end

    // state next values
    always_comb begin
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        decision_next = decision_reg;
        active_next   = active_reg;
        if (accept) begin
            if (s_restart) begin
                step_x_next   = '0;
                step_y_next   = COORD_BITS'(cfg.radius);
                decision_next = OUT_BITS'(1) - OUT_BITS'(cfg.radius);
                active_next   = 1'b1;
            end else if (!finished) begin
                step_x_next   = x_inc[COORD_BITS-1:0];
                step_y_next   = y_dec[COORD_BITS-1:0];
                decision_next = dec_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            active_reg   <= 1'b0;
        end else begin
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
            active_reg   <= active_next;
        end
    end

endmodule

>>> src/mcr_back.sv
// pixel back: expands step commands into eight symmetric pixels or a done result
module mcr_back
    import mcr_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  q_stat_t                    q_stat,
    input  cmd_t                       pop_data,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_BITS-1:0] m_pixel_x,
    output logic signed [OUT_BITS-1:0] m_pixel_y,
    output logic                       m_pixel_valid,
    output logic                       m_last_of_step,
    output logic                       m_circle_done
);

    cmd_t                cmd_reg, cmd_next;
    logic                busy_reg, busy_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0] px_reg, px_next;
    logic [OUT_BITS-1:0] py_reg, py_next;
    logic                pv_reg, pv_next;
    logic                last_reg, last_next;
    logic                done_reg, done_next;

    logic                out_free;
    logic                emit;
    logic                is_last;
    logic [OUT_BITS-1:0] off_a;
    logic [OUT_BITS-1:0] off_b;
    logic [OUT_BITS-1:0] cx_ext;
    logic [OUT_BITS-1:0] cy_ext;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = busy_reg && out_free;
    assign is_last  = cmd_reg.done || (idx_reg == LAST_IDX);
    assign pop      = q_stat.not_empty && (!busy_reg || (emit && is_last));

    // symmetric pixel of the current index: bit 2 swaps, bit 0 and 1 negate
    always_comb begin
        cx_ext = OUT_BITS'(cmd_reg.center_x);
        cy_ext = OUT_BITS'(cmd_reg.center_y);
        off_a  = idx_reg[2] ? OUT_BITS'(cmd_reg.y) : OUT_BITS'(cmd_reg.x);
        off_b  = idx_reg[2] ? OUT_BITS'(cmd_reg.x) : OUT_BITS'(cmd_reg.y);
        px_next = idx_reg[0] ? cx_ext - off_a : cx_ext + off_a;
        py_next = idx_reg[1] ? cy_ext - off_b : cy_ext + off_b;
        pv_next   = 1'b1;
        last_next = is_last;
        done_next = 1'b0;
        if (cmd_reg.done) begin
            px_next = '0;
            py_next = '0;
            pv_next = 1'b0;
            done_next = 1'b1;
        end
    end

    // command sequencing
    always_comb begin
        cmd_next  = cmd_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop) begin
            cmd_next  = pop_data;
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (emit) begin
            busy_next = !is_last;
            idx_next  = idx_reg + 1'b1;
        end
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (emit) begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pv_reg   <= pv_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = px_reg;
    assign m_pixel_y      = py_reg;
    assign m_pixel_valid  = pv_reg;
    assign m_last_of_step = last_reg;
    assign m_circle_done  = done_reg;

endmodule

>>> sim/tb_midpoint_circle_rasterizer_unit.sv
// self-checking testbench of the midpoint circle rasterizer: directed and random ticks
module tb_midpoint_circle_rasterizer_unit;
    import mcr_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    // one result as it should appear on the m_ channel
    typedef struct packed {
        logic signed [OUT_BITS-1:0] px;
        logic signed [OUT_BITS-1:0] py;
        logic                       valid;
        logic                       last;
        logic                       done;
    } pixel_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_restart = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [OUT_BITS-1:0] m_pixel_x;
    logic signed [OUT_BITS-1:0] m_pixel_y;
    logic                       m_pixel_valid;
    logic                       m_last_of_step;
    logic                       m_circle_done;

    // register copies and stepping state of the predictor
    logic [COORD_BITS-1:0]      cur_center_x = CENTER_X_RST;
    logic [COORD_BITS-1:0]      cur_center_y = CENTER_Y_RST;
    logic [RADIUS_BITS-1:0]     cur_radius = RADIUS_RST;
    logic [COORD_BITS-1:0]      walk_x = '0;
    logic [COORD_BITS-1:0]      walk_y = '0;
    logic signed [OUT_BITS-1:0] walk_d = '0;
    logic                       walk_active = 1'b0;

    pixel_result_t expected_pixels[$];

    // idling controls and run statistics
    bit tx_busy = 1'b0;
    bit rx_busy = 1'b0;
    int rx_hold_req = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int circles_started = 0;
    int fault_count = 0;

    midpoint_circle_rasterizer_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_valid  (m_pixel_valid),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

    // clock
    always #5 aclk = ~aclk;

    // run limit
    initial begin
        #5000000;
        $display("timeout with %0d results outstanding", expected_pixels.size());
        $display("tb_midpoint_circle_rasterizer_unit: errors");
        $finish;
    end

    function automatic bit circle_finished();
        return !walk_active || (walk_x >= walk_y);
    endfunction

    // predict the results of one tick and queue them
    task automatic rasterize_tick(input logic restart);
        int x, y, p, cx, cy, k, dx, dy;
        pixel_result_t r;
        if (restart) begin
            walk_x = '0;
            walk_y = COORD_BITS'(cur_radius);
            walk_d = OUT_BITS'(1 - int'(cur_radius));
            walk_active = 1'b1;
        end else if (circle_finished()) begin
            r.px = '0;
            r.py = '0;
            r.valid = 1'b0;
            r.last = 1'b1;
            r.done = 1'b1;
            expected_pixels.push_back(r);
        end else begin
            x = int'(walk_x);
            y = int'(walk_y);
            cx = int'(cur_center_x);
            cy = int'(cur_center_y);
            // eight octant reflections in output order
            for (k = 0; k < PIXELS_PER_STEP; k++) begin
                if (k < 4) begin
                    dx = (k % 2) ? -x : x;
                    dy = (k < 2) ? y : -y;
                end else begin
                    dx = (k % 2) ? -y : y;
                    dy = (k < 6) ? x : -x;
                end
                r.px = OUT_BITS'(cx + dx);
                r.py = OUT_BITS'(cy + dy);
                r.valid = 1'b1;
                r.last = (k == PIXELS_PER_STEP - 1);
                r.done = 1'b0;
                expected_pixels.push_back(r);
            end
            // decision update
            p = int'(walk_d);
            x = x + 1;
            if (p < 0) begin
                p = p + 2 * x + 1;
            end else begin
                y = y - 1;
                p = p + 2 * (x - y) + 1;
            end
            walk_x = COORD_BITS'(x);
            walk_y = COORD_BITS'(y);
            walk_d = OUT_BITS'(p);
        end
    endtask

    // offer one tick and wait for its transfer
    task automatic send_tick(input logic restart);
        int gap;
        gap = tx_busy ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        rasterize_tick(restart);
        ticks_sent++;
        if (restart) circles_started++;
    endtask

    // stop offering and let every queued result and any restart drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CENTER_X: begin
                cur_center_x = data;
            end
            CFG_CENTER_Y: begin
                cur_center_y = data;
            end
            CFG_RADIUS: begin
                cur_radius = data[RADIUS_BITS-1:0];
            end
            default: begin
            end
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    // result receiver with random holds and one requested long hold
    initial begin : receiver
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = rx_busy ? $urandom_range(0, 11) : 0;
            if (rx_hold_req > 0) begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        pixel_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result x=%0d y=%0d pv=%b last=%b done=%b",
                             m_pixel_x, m_pixel_y, m_pixel_valid, m_last_of_step,
                             m_circle_done);
                fault_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_pixel_x !== want.px || m_pixel_y !== want.py ||
                    m_pixel_valid !== want.valid || m_last_of_step !== want.last ||
                    m_circle_done !== want.done) begin
                    if (fault_count < 10)
                        $display({"mismatch at result %0d: ",
                                  "exp x=%0d y=%0d pv=%b last=%b done=%b, ",
                                  "got x=%0d y=%0d pv=%b last=%b done=%b"},
                                 results_seen, want.px, want.py, want.valid, want.last,
                                 want.done, m_pixel_x, m_pixel_y, m_pixel_valid,
                                 m_last_of_step, m_circle_done);
                    fault_count++;
                end
            end
        end
    end

    // advance ticks before any restart give the done result
    task automatic test_idle_advance();
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // first steps of the reset-default circle
    task automatic test_default_circle();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // zero radius is finished at once
    task automatic test_zero_radius();
        write_reg(CFG_RADIUS, '0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // tiny circle walked to the end and past it
    task automatic test_small_full_circle();
        write_reg(CFG_CENTER_X, 11'd500);
        write_reg(CFG_CENTER_Y, 11'd9);
        write_reg(CFG_RADIUS, 11'd3);
        tx_busy = 1'b1;
        rx_busy = 1'b1;
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
    endtask

    // corner centers with the largest radius, upper radius bit dropped
    task automatic test_coordinate_extremes();
        write_reg(CFG_CENTER_X, '0);
        write_reg(CFG_CENTER_Y, '0);
        write_reg(CFG_RADIUS, 11'h7ff);
        send_tick(1'b1);
        send_tick(1'b0);
        write_reg(CFG_CENTER_X, 11'h7ff);
        write_reg(CFG_CENTER_Y, 11'h7ff);
        // write to a missing register must leave everything alone
        write_reg(CFG_UNUSED, 11'h555);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // center is picked up by the next step, radius only at restart
    task automatic test_center_between_steps();
        write_reg(CFG_CENTER_X, 11'd300);
        write_reg(CFG_CENTER_Y, 11'd400);
        write_reg(CFG_RADIUS, 11'd20);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        write_reg(CFG_CENTER_X, 11'd1200);
        write_reg(CFG_CENTER_Y, 11'd7);
        write_reg(CFG_RADIUS, 11'd5);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // restart in the middle of a circle
    task automatic test_restart_mid_circle();
        send_tick(1'b1);
        send_tick(1'b0);
        write_reg(CFG_RADIUS, 11'd20);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // long receiver hold while the sender keeps pushing
    task automatic test_backpressure();
        write_reg(CFG_RADIUS, 11'd40);
        tx_busy = 1'b0;
        rx_busy = 1'b0;
        send_tick(1'b1);
        rx_hold_req = 150;
        repeat (12) send_tick(1'b0);
    endtask

    // random circles, mostly well-formed with some noise
    task automatic test_random_circles();
        int start_ticks, sel, rad, cap, n, extra;
        start_ticks = ticks_sent;
        while (ticks_sent - start_ticks < 130) begin
            tx_busy = ($urandom_range(0, 3) != 0);
            rx_busy = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
                write_reg(CFG_CENTER_X, CFG_DATA_BITS'($urandom_range(0, 2047)));
            if ($urandom_range(0, 1))
                write_reg(CFG_CENTER_Y, CFG_DATA_BITS'($urandom_range(0, 2047)));
            sel = $urandom_range(0, 19);
            if (sel < 14)
                rad = $urandom_range(0, 12);
            else if (sel < 19)
                rad = $urandom_range(13, 60);
            else
                rad = $urandom_range(61, 1023);
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_RADIUS,
                          CFG_DATA_BITS'(($urandom_range(0, 1) << RADIUS_BITS) | rad));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom_range(0, 2047)));
            // occasionally skip the restart and keep stepping the old state
            if ($urandom_range(0, 9) != 0)
                send_tick(1'b1);
            cap = $urandom_range(6, 40);
            n = 0;
            while (!circle_finished() && n < cap) begin
                send_tick($urandom_range(0, 15) == 0);
                n++;
            end
            extra = $urandom_range(0, 2);
            repeat (extra) send_tick(1'b0);
        end
    endtask

    // main sequence
    initial begin : main
        int guard;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_advance();
        test_default_circle();
        test_zero_radius();
        test_small_full_circle();
        test_coordinate_extremes();
        test_center_between_steps();
        test_restart_mid_circle();
        test_backpressure();
        test_random_circles();
        // drain
        s_valid <= 1'b0;
        guard = 0;
        while (expected_pixels.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (expected_pixels.size() != 0) begin
            $display("%0d predicted results never arrived", expected_pixels.size());
            fault_count++;
        end
        $display("run covered %0d ticks over %0d circle starts, %0d register writes",
                 ticks_sent, circles_started, reg_writes);
        $display("%0d results compared, %0d failures", results_seen, fault_count);
        if (fault_count == 0) begin
            $display("tb_midpoint_circle_rasterizer_unit: clean");
        end else begin
            $display("tb_midpoint_circle_rasterizer_unit: errors");
        end
        $finish;
    end

endmodule
